FILE: hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, constants and byte classification functions for the
// C-like token lexer.
// ----------------------------------------------------------------------------
package clt_pkg;

    // Text size and the resulting saturation point of byte positions.
    localparam int TEXT_BYTES  = 65536;
    localparam int POS_MAX_INT = (TEXT_BYTES - 1 < 65535) ? TEXT_BYTES - 1 : 65535;
    localparam logic [15:0] POS_MAX = 16'(POS_MAX_INT);
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Largest number of tokens that one byte can cause.
    localparam int MAX_TOKENS = 3;

    // Token kinds.
    typedef logic [4:0] kind_t;
    localparam kind_t K_END     = 5'd0;
    localparam kind_t K_IDENT   = 5'd18;
    localparam kind_t K_NUMBER  = 5'd19;
    localparam kind_t K_INVALID = 5'd20;

    // Character codes used by the scanner.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_SWALLOW
    } mode_t;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] offset;
        logic [15:0] size;
        logic [15:0] line;
    } token_t;

    // All tokens caused by one byte, in order.
    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic [1:0]              count;
    } entry_t;

    // Push side of the queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // One-byte punctuation tokens; zero means the byte is not punctuation.
    function automatic kind_t punct_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            8'h3B:   k = 5'd1;   // semicolon
            8'h3A:   k = 5'd2;   // colon
            8'h7B:   k = 5'd3;   // open brace
            8'h7D:   k = 5'd4;   // close brace
            8'h28:   k = 5'd5;   // open paren
            8'h29:   k = 5'd6;   // close paren
            8'h5B:   k = 5'd7;   // open bracket
            8'h5D:   k = 5'd8;   // close bracket
            8'h2C:   k = 5'd9;   // comma
            8'h3C:   k = 5'd10;  // less than
            8'h3E:   k = 5'd11;  // greater than
            8'h23:   k = 5'd12;  // hash
            8'h21:   k = 5'd13;  // bang
            8'h3D:   k = 5'd14;  // equals
            8'h5C:   k = 5'd15;  // backslash
            8'h7C:   k = 5'd16;  // pipe
            8'h2A:   k = 5'd17;  // star
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/clt_if.sv
// ----------------------------------------------------------------------------
// clt_byte_if / clt_token_if
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface clt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface clt_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_size;
    logic [15:0] token_line;
    logic        run_last;

    modport source (output valid, output token_kind, output token_offset,
                    output token_size, output token_line, output run_last,
                    input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_size, input token_line, input run_last,
                    output ready);
endinterface

FILE: hdl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Scanner front end: classifies each accepted byte, updates the scan state
// and gathers the tokens that the byte causes into one queue entry.
// ----------------------------------------------------------------------------
module clt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     in_byte,
    input  logic           in_eot,
    output clt_pkg::push_t push
);
    import clt_pkg::*;

    mode_t       mode_reg, mode_next, mode_step;
    logic [15:0] start_off_reg, start_off_next, start_off_step;
    logic [15:0] run_len_reg, run_len_next, run_len_step;
    logic [15:0] pos_reg, pos_next, pos_step;
    logic [15:0] line_reg, line_next, line_step;
    logic [15:0] start_line_reg, start_line_next, start_line_step;

    logic        letter, digit, under, dot, is_ws, is_lf, is_nul, is_quote;
    kind_t       pk;
    logic        ident_cont, number_cont, run_ends, do_idle, own_invalid;
    logic [15:0] run_len_inc, pos_inc;

    token_t [3:0] cand;
    logic   [3:0] cand_v;
    entry_t       entry;

    // Byte classes.
    assign letter   = is_letter(in_byte);
    assign digit    = is_digit(in_byte);
    assign under    = in_byte == CH_UNDER;
    assign dot      = in_byte == CH_DOT;
    assign is_lf    = in_byte == CH_LF;
    assign is_nul   = in_byte == CH_NUL;
    assign is_quote = in_byte == CH_QUOTE;
    assign is_ws    = in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR;
    assign pk       = punct_kind(in_byte);

    assign ident_cont  = letter || digit || under || dot;
    assign number_cont = digit || dot;
    assign run_ends    = (mode_reg == MODE_IDENT && !ident_cont)
                      || (mode_reg == MODE_NUMBER && !number_cont);
    assign do_idle     = mode_reg == MODE_IDLE || run_ends;
    assign own_invalid = !(is_ws || is_lf || is_nul || pk != K_END || is_quote
                           || letter || under || digit);

    // Saturating increments.
    assign run_len_inc = (run_len_reg == CNT_MAX) ? CNT_MAX : run_len_reg + 16'd1;
    assign pos_inc     = (pos_reg >= POS_MAX) ? POS_MAX : pos_reg + 16'd1;

    // Next scan state for this byte.
    always_comb
    begin
        mode_step       = mode_reg;
        start_off_step  = start_off_reg;
        run_len_step    = run_len_reg;
        line_step       = line_reg;
        start_line_step = start_line_reg;
        pos_step        = pos_inc;
        if (do_idle)
        begin
            mode_step = MODE_IDLE;
            if (is_lf)
            begin
                line_step = (line_reg == CNT_MAX) ? CNT_MAX : line_reg + 16'd1;
            end
            else if (is_quote)
            begin
                mode_step       = MODE_STRING;
                start_off_step  = pos_inc;
                run_len_step    = 16'd0;
                start_line_step = line_reg;
            end
            else if (letter || under)
            begin
                mode_step       = MODE_IDENT;
                start_off_step  = pos_reg;
                run_len_step    = 16'd1;
                start_line_step = line_reg;
            end
            else if (digit)
            begin
                mode_step       = MODE_NUMBER;
                start_off_step  = pos_reg;
                run_len_step    = 16'd1;
                start_line_step = line_reg;
            end
            else if (own_invalid)
            begin
                mode_step = MODE_SWALLOW;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    run_len_step = run_len_inc;
                end
                MODE_STRING:
                begin
                    if (is_quote)
                    begin
                        mode_step = MODE_IDLE;
                    end
                    else
                    begin
                        run_len_step = run_len_inc;
                        if (in_byte == CH_BSL)
                        begin
                            mode_step = MODE_ESCAPE;
                        end
                    end
                end
                MODE_ESCAPE:
                begin
                    run_len_step = run_len_inc;
                    mode_step    = MODE_STRING;
                end
                default:
                begin
                    mode_step = MODE_IDLE;
                end
            endcase
        end

        // End of text returns every register to its reset value.
        if (in_eot)
        begin
            mode_next       = MODE_IDLE;
            start_off_next  = 16'd0;
            run_len_next    = 16'd0;
            pos_next        = 16'd0;
            line_next       = 16'd0;
            start_line_next = 16'd0;
        end
        else
        begin
            mode_next       = mode_step;
            start_off_next  = start_off_step;
            run_len_next    = run_len_step;
            pos_next        = pos_step;
            line_next       = line_step;
            start_line_next = start_line_step;
        end
    end

    // Candidate tokens in emission order: the run that this byte closes, the
    // byte's own token, the run flushed at end of text and the end token.
    always_comb
    begin
        int unsigned n;
        n = 0;

        cand[0].kind   = (mode_reg == MODE_NUMBER) ? K_NUMBER : K_IDENT;
        cand[0].offset = start_off_reg;
        cand[0].size   = run_len_reg;
        cand[0].line   = start_line_reg;
        cand_v[0]      = run_ends || (mode_reg == MODE_STRING && is_quote);

        cand[1].kind   = is_nul ? K_END : (pk != K_END) ? pk : K_INVALID;
        cand[1].offset = pos_reg;
        cand[1].size   = 16'd1;
        cand[1].line   = line_reg;
        cand_v[1]      = do_idle && (is_nul || pk != K_END || own_invalid);

        cand[2].kind   = (mode_step == MODE_NUMBER) ? K_NUMBER : K_IDENT;
        cand[2].offset = start_off_step;
        cand[2].size   = run_len_step;
        cand[2].line   = start_line_step;
        cand_v[2]      = in_eot && (mode_step == MODE_IDENT || mode_step == MODE_NUMBER
                                    || mode_step == MODE_STRING || mode_step == MODE_ESCAPE);

        cand[3].kind   = K_END;
        cand[3].offset = pos_step;
        cand[3].size   = 16'd0;
        cand[3].line   = line_step;
        cand_v[3]      = in_eot;

        // Pack the valid candidates into the low slots.
        entry = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n < MAX_TOKENS)
            begin
                entry.tok[n[1:0]] = cand[i];
                n = n + 1;
            end
        end
        entry.count = n[1:0];
    end

    assign push.valid = in_fire && entry.count != 2'd0;
    assign push.entry = entry;

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            start_off_reg  <= 16'd0;
            run_len_reg    <= 16'd0;
            pos_reg        <= 16'd0;
            line_reg       <= 16'd0;
            start_line_reg <= 16'd0;
        end
        else if (in_fire)
        begin
            mode_reg       <= mode_next;
            start_off_reg  <= start_off_next;
            run_len_reg    <= run_len_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            start_line_reg <= start_line_next;
        end
    end

endmodule

FILE: hdl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Short register queue of token groups between front and back end.
// ----------------------------------------------------------------------------
module clt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  clt_pkg::push_t push,
    input  logic           pop,
    output logic           full,
    output clt_pkg::head_t head
);
    import clt_pkg::*;

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign full       = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = slots_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

FILE: hdl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Back end: hands out the tokens of the head entry one beat at a time and
// marks the last token of each byte.
// ----------------------------------------------------------------------------
module clt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  clt_pkg::head_t   head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output clt_pkg::token_t  out_tok,
    output logic             out_last
);
    import clt_pkg::*;

    logic [1:0] sub_reg, sub_next;
    logic       fire;

    assign out_valid = head.valid;
    assign out_tok   = head.entry.tok[sub_reg];
    assign out_last  = sub_reg == head.entry.count - 2'd1;
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    // Token index within the head entry.
    always_comb
    begin
        if (pop)
        begin
            sub_next = 2'd0;
        end
        else if (fire)
        begin
            sub_next = sub_reg + 2'd1;
        end
        else
        begin
            sub_next = sub_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 2'd0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

FILE: hdl/c_like_token_lexer.sv
// ----------------------------------------------------------------------------
// c_like_token_lexer
// Streaming lexer that cuts C-like source text into tokens.
// ----------------------------------------------------------------------------
// Usage:
//   text  : one source byte per beat with an end-of-text flag on the final
//           byte of a text.  The next beat after end of text starts a new text.
//   token : one token per beat (kind, offset, size, line) with run_last set
//           on the last token caused by one input byte.
// A byte may cause zero to three tokens.  The front end handles one byte per
// cycle while the queue is not full and writes its tokens as one group into
// a four-entry queue; the back end drains one token per cycle while the
// receiver is ready.  Throughput is one byte per cycle while each byte yields
// at most one token and the receiver is ready; a byte with two or three
// tokens holds the output port until all are taken, and the queue absorbs
// bursts.  When the receiver stalls, the queue fills and text.ready drops
// once all four entries hold tokens; bytes with no token never occupy an
// entry.  Reset clears scan state and empties the queue at once; no sweep.
// ----------------------------------------------------------------------------
module c_like_token_lexer (
    input  logic               clk,
    input  logic               rst_n,
    clt_byte_if.sink           text,
    clt_token_if.source        token
);
    import clt_pkg::*;

    push_t  push;
    head_t  head;
    token_t out_tok;
    logic   full, pop, in_fire;

    assign text.ready = !full;
    assign in_fire    = text.valid && !full;

    clt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (text.text_byte),
        .in_eot  (text.end_of_text),
        .push    (push)
    );

    clt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    clt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (token.valid),
        .out_ready (token.ready),
        .out_tok   (out_tok),
        .out_last  (token.run_last)
    );

    assign token.token_kind   = out_tok.kind;
    assign token.token_offset = out_tok.offset;
    assign token.token_size   = out_tok.size;
    assign token.token_line   = out_tok.line;

endmodule

FILE: hdl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level assertions for the lexer, bound to the top level.
// ----------------------------------------------------------------------------
module clt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  token_kind,
    input  logic [15:0] token_size,
    input  logic        run_last
);
    import clt_pkg::*;

    // A stalled token holds its kind and its last mark.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(run_last))
        else $error("token changed while stalled");

    // Kinds stay within the defined range.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= K_INVALID)
        else $error("token kind out of range");

    // The end-of-text token has size zero and always closes its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_END && token_size == 16'd0 |-> run_last)
        else $error("end-of-text token not last");

    // Punctuation tokens are one byte long.
    a_punct_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_END && token_kind < K_IDENT |-> token_size == 16'd1)
        else $error("punctuation token size not one");

    // Invalid tokens are one byte long.
    a_invalid_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_INVALID |-> token_size == 16'd1)
        else $error("invalid token size not one");

endmodule

bind c_like_token_lexer clt_checker u_clt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (token.valid),
    .out_ready  (token.ready),
    .token_kind (token.token_kind),
    .token_size (token.token_size),
    .run_last   (token.run_last)
);
